[design/pwm_divider_range_search_assert.svh]
// assertion macros used by the checker file
// no dependencies; expects clk and rst in the scope of use
`ifndef PWM_DIVIDER_RANGE_SEARCH_ASSERT_SVH
`define PWM_DIVIDER_RANGE_SEARCH_ASSERT_SVH

// same-cycle implication
`define PDRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdrs check failed");

// next-cycle implication
`define PDRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdrs check failed");

`endif

[design/pdrs_pkg.sv]
// shared constants, types and helpers of the pwm divider range search
// no dependencies
package pdrs_pkg;

  localparam int MAX_DIVIDER    = 256;
  localparam int MAX_RANGE      = 65536;
  localparam int FREQ_FRAC_BITS = 8;

  localparam int BASE_W  = 32;
  localparam int NUM_W   = BASE_W + FREQ_FRAC_BITS;
  localparam int FREQ_W  = 40;
  localparam int DUTY_W  = 16;
  localparam int CH_W    = 3;
  localparam int STAT_W  = 3;
  localparam int PIN_W   = 5;
  localparam int DIV_W   = 9;
  localparam int RANGE_W = 17;
  localparam int CMP_W   = 16;
  localparam int DEN_W   = 48;
  localparam int PROD_W  = DUTY_W + RANGE_W;
  localparam int IN_W    = 64;
  localparam int OUT_W   = 96;

  localparam logic [BASE_W-1:0] BASE_RESET = 32'd24038400;

  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_CHANNEL = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_FREQ    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_DUTY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_FIT      = 3'd4;

  typedef struct packed {
    logic                valid;
    logic                last;
    logic                skip;
    logic [STAT_W-1:0]   status;
    logic [CH_W-1:0]     channel;
    logic [DUTY_W-1:0]   duty;
    logic [FREQ_W-1:0]   freq;
    logic [DIV_W-1:0]    dv;
    logic [RANGE_W-1:0]  range;
  } slot_t;

  typedef struct packed {
    slot_t              slot;
    logic [DEN_W-1:0]   rem;
    logic [NUM_W-1:0]   num;
    logic [NUM_W-1:0]   q;
    logic [DEN_W-1:0]   d;
  } cell_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [PIN_W-1:0]   pin_number;
    logic [DIV_W-1:0]   clock_divider;
    logic [RANGE_W-1:0] period_range;
    logic [CMP_W-1:0]   compare_value;
    logic [FREQ_W-1:0]  achieved_freq;
  } result_t;

  function automatic logic [PIN_W-1:0] pin_of(input logic [CH_W-1:0] ch);
    case (ch)
      3'd1:    pin_of = 5'd21;
      3'd2:    pin_of = 5'd22;
      3'd3:    pin_of = 5'd2;
      3'd4:    pin_of = 5'd9;
      default: pin_of = 5'd0;
    endcase
  endfunction

endpackage

[design/pdrs_div_cell.sv]
// one restoring division step: shifts in a dividend bit, trial subtract
// depends on pdrs_pkg
module pdrs_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  pdrs_pkg::cell_t din,
  output pdrs_pkg::cell_t dout
);
  import pdrs_pkg::*;

  logic [DEN_W:0]   t;
  logic [DEN_W:0]   diff;
  logic             ge;
  cell_t            nxt;
  cell_t            pay;
  logic             vld;

  always_comb begin
    t    = {din.rem, din.num[NUM_W-1]};
    ge   = t >= {1'b0, din.d};
    diff = t - {1'b0, din.d};
    nxt      = din;
    nxt.rem  = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
    nxt.num  = {din.num[NUM_W-2:0], 1'b0};
    nxt.q    = {din.q[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    pay <= nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= din.slot.valid;
    end
  end

  always_comb begin
    dout            = pay;
    dout.slot.valid = vld;
  end
endmodule

[design/pdrs_fit.sv]
// rounds the range quotient, flags out-of-range dividers, forms divider*range
// depends on pdrs_pkg
module pdrs_fit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [pdrs_pkg::BASE_W-1:0]    base_clock_hz,
  input  pdrs_pkg::cell_t                din,
  output pdrs_pkg::cell_t                dout
);
  import pdrs_pkg::*;

  logic [DEN_W:0]   twice_r;
  logic             up;
  logic [NUM_W:0]   rsum;
  logic             bad;
  slot_t            s1;
  logic             v1;
  slot_t            s1_next;
  logic [DIV_W+RANGE_W-1:0] prod;
  cell_t            pay;
  logic             v2;

  always_comb begin
    twice_r = {din.rem, 1'b0};
    up      = twice_r >= {1'b0, din.d};
    rsum    = {1'b0, din.q} + {{NUM_W{1'b0}}, up};
    bad     = (din.q == '0) || (din.q > NUM_W'(MAX_RANGE)) ||
              ((din.q == NUM_W'(MAX_RANGE)) && (din.rem != '0));
    s1_next       = din.slot;
    s1_next.skip  = din.slot.skip | bad;
    s1_next.range = rsum[RANGE_W-1:0];
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
  end

  always_comb begin
    prod = s1.dv * s1.range;
  end

  always_ff @(posedge clk) begin
    pay.slot <= s1;
    pay.rem  <= '0;
    pay.num  <= {base_clock_hz, {FREQ_FRAC_BITS{1'b0}}};
    pay.q    <= '0;
    pay.d    <= DEN_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= din.slot.valid;
      v2 <= v1;
    end
  end

  always_comb begin
    dout            = pay;
    dout.slot.valid = v2;
  end
endmodule

[design/pdrs_select.sv]
// rounds achieved frequency, keeps the best divider, forms the compare value
// depends on pdrs_pkg
module pdrs_select (
  input  logic              clk,
  input  logic              rst,
  input  pdrs_pkg::cell_t   din,
  output logic              res_valid,
  output pdrs_pkg::result_t res
);
  import pdrs_pkg::*;

  // stage a: achieved frequency and error
  logic [DEN_W:0]   twice_r;
  logic             up;
  logic [NUM_W:0]   asum;
  logic [FREQ_W-1:0] ach_c;
  slot_t            sa;
  logic             va;
  logic [FREQ_W-1:0] ach_a;
  logic [FREQ_W-1:0] err_a;

  always_comb begin
    twice_r = {din.rem, 1'b0};
    up      = twice_r >= {1'b0, din.d};
    asum    = {1'b0, din.q} + {{NUM_W{1'b0}}, up};
    ach_c   = asum[FREQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    sa    <= din.slot;
    ach_a <= ach_c;
    err_a <= (ach_c >= din.slot.freq) ? ach_c - din.slot.freq : din.slot.freq - ach_c;
  end

  // stage b: running best over one item
  logic              found;
  logic [FREQ_W-1:0] best_err;
  logic [DIV_W-1:0]  best_div;
  logic [RANGE_W-1:0] best_range;
  logic [FREQ_W-1:0] best_ach;
  logic              take;
  logic              found_next;
  logic [FREQ_W-1:0] best_err_next;
  logic [DIV_W-1:0]  best_div_next;
  logic [RANGE_W-1:0] best_range_next;
  logic [FREQ_W-1:0] best_ach_next;

  always_comb begin
    take = va && !sa.skip && (!found || (err_a < best_err));
    found_next      = found | take;
    best_err_next   = take ? err_a : best_err;
    best_div_next   = take ? sa.dv : best_div;
    best_range_next = take ? sa.range : best_range;
    best_ach_next   = take ? ach_a : best_ach;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (va && sa.last) begin
      found <= 1'b0;
    end else begin
      found <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    best_err   <= best_err_next;
    best_div   <= best_div_next;
    best_range <= best_range_next;
    best_ach   <= best_ach_next;
  end

  // stage c: final status and the product's operands registered
  logic              vc;
  logic [STAT_W-1:0] stat_c;
  logic [CH_W-1:0]   ch_c;
  logic [DUTY_W-1:0] duty_c;
  logic [DIV_W-1:0]  div_c;
  logic [RANGE_W-1:0] range_c;
  logic [FREQ_W-1:0] achv_c;

  always_ff @(posedge clk) begin
    ch_c    <= sa.channel;
    duty_c  <= sa.duty;
    div_c   <= best_div_next;
    range_c <= best_range_next;
    achv_c  <= best_ach_next;
    if (sa.status != ST_OK) begin
      stat_c <= sa.status;
    end else if (!found_next) begin
      stat_c <= ST_NO_FIT;
    end else begin
      stat_c <= ST_OK;
    end
  end

  // stage d: product registered
  logic              vd;
  logic [STAT_W-1:0] stat_d;
  logic [CH_W-1:0]   ch_d;
  logic [DIV_W-1:0]  div_d;
  logic [RANGE_W-1:0] range_d;
  logic [FREQ_W-1:0] ach_d;
  logic [PROD_W-1:0] prod_d;

  always_ff @(posedge clk) begin
    stat_d  <= stat_c;
    ch_d    <= ch_c;
    div_d   <= div_c;
    range_d <= range_c;
    ach_d   <= achv_c;
    prod_d  <= duty_c * range_c;
  end

  // stage e: round, clamp, zero on error
  logic [PROD_W:0]   psum;
  logic [RANGE_W-1:0] cmp_r;
  logic [RANGE_W-1:0] cmp_lo;
  logic [RANGE_W-1:0] cmp_hi;
  result_t           res_next;

  always_comb begin
    psum   = {1'b0, prod_d} + (PROD_W+1)'(32768);
    cmp_r  = psum[PROD_W-1:DUTY_W];
    cmp_lo = (cmp_r == '0) ? RANGE_W'(1) : cmp_r;
    cmp_hi = (cmp_lo >= range_d) ? range_d - RANGE_W'(1) : cmp_lo;
    res_next = '0;
    res_next.status = stat_d;
    if (stat_d == ST_OK) begin
      res_next.pin_number    = pin_of(ch_d);
      res_next.clock_divider = div_d;
      res_next.period_range  = range_d;
      res_next.compare_value = cmp_hi[CMP_W-1:0];
      res_next.achieved_freq = ach_d;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      va        <= din.slot.valid;
      vc        <= va && sa.last;
      vd        <= vc;
      res_valid <= vd;
    end
  end
endmodule

[design/pwm_divider_range_search.sv]
// top level of the pwm divider range search: issue sequencer, two division
// chains, result queue; depends on pdrs_pkg, pdrs_div_cell, pdrs_fit, pdrs_select
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      channel, target_freq, duty_frac
//  m_axis    out  m_axis_tvalid/tready      status .. achieved_freq
//  cfg       in   cfg_wen                   base_clock_hz
//
// a valid request is taken, then issues one candidate divider per cycle, 1 through
// MAX_DIVIDER, into a chain of 40 range-division cells and 40 frequency-division
// cells; no new request is taken until the last divider has been issued
// a rejected request issues a single skipped slot; m_axis_tvalid rises once that
// slot or the last divider has passed both chains, the fit and select stages
// up to two results wait in the output queue, so a stalled consumer blocks
// new requests only once two are waiting or in flight
// rst is synchronous and restores base_clock_hz to 24038400
module pwm_divider_range_search (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // channel[2:0], target_freq[42:3], duty_frac[58:43], zero fill
  input  logic [pdrs_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status[2:0], pin_number[7:3], clock_divider[16:8], period_range[33:17],
  // compare_value[49:34], achieved_freq[89:50], zero fill
  output logic [pdrs_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                           cfg_wen,
  input  logic [pdrs_pkg::BASE_W-1:0]    cfg_wdata
);
  import pdrs_pkg::*;

  // base clock register
  logic [BASE_W-1:0] base_clock_hz;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_clock_hz <= BASE_RESET;
    end else if (cfg_wen) begin
      base_clock_hz <= cfg_wdata;
    end
  end

  // input fields
  logic [CH_W-1:0]   in_ch;
  logic [FREQ_W-1:0] in_freq;
  logic [DUTY_W-1:0] in_duty;
  logic [STAT_W-1:0] in_status;
  logic              accept;

  assign in_ch   = s_axis_tdata[CH_W-1:0];
  assign in_freq = s_axis_tdata[CH_W+FREQ_W-1:CH_W];
  assign in_duty = s_axis_tdata[CH_W+FREQ_W+DUTY_W-1:CH_W+FREQ_W];

  always_comb begin
    if (in_ch < 3'd1 || in_ch > 3'd4) begin
      in_status = ST_BAD_CHANNEL;
    end else if (in_freq == '0) begin
      in_status = ST_BAD_FREQ;
    end else if (in_duty == '0) begin
      in_status = ST_BAD_DUTY;
    end else begin
      in_status = ST_OK;
    end
  end

  // issue sequencer
  logic              busy;
  logic [DIV_W-1:0]  dv;
  logic [CH_W-1:0]   ch_r;
  logic [FREQ_W-1:0] freq_r;
  logic [DUTY_W-1:0] duty_r;
  logic [1:0]        pending;
  logic              pop;
  logic              issue_last;

  assign s_axis_tready = !busy && (pending < 2'd2);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign issue_last    = (dv == DIV_W'(MAX_DIVIDER));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      dv   <= '0;
    end else if (busy) begin
      dv <= dv + DIV_W'(1);
      if (issue_last) begin
        busy <= 1'b0;
      end
    end else if (accept && in_status == ST_OK) begin
      busy <= 1'b1;
      dv   <= DIV_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r   <= in_ch;
      freq_r <= in_freq;
      duty_r <= in_duty;
    end
  end

  // issue register: divider times target frequency
  cell_t                    mul_c;
  cell_t                    mul_pay;
  logic                     mul_v;
  logic [DIV_W+FREQ_W-1:0]  den;

  always_comb begin
    den = dv * freq_r;
    mul_c = '0;
    mul_c.num = {base_clock_hz, {FREQ_FRAC_BITS{1'b0}}};
    if (busy) begin
      mul_c.slot.last    = issue_last;
      mul_c.slot.status  = ST_OK;
      mul_c.slot.channel = ch_r;
      mul_c.slot.duty    = duty_r;
      mul_c.slot.freq    = freq_r;
      mul_c.slot.dv      = dv;
      mul_c.d            = den[DEN_W-1:0];
    end else begin
      // rejected request travels as one skipped slot to keep order
      mul_c.slot.last    = 1'b1;
      mul_c.slot.skip    = 1'b1;
      mul_c.slot.status  = in_status;
      mul_c.d            = DEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    mul_pay <= mul_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else begin
      mul_v <= busy || (accept && in_status != ST_OK);
    end
  end

  // range division chain
  cell_t chain_a [0:NUM_W];
  cell_t chain_b [0:NUM_W];
  cell_t fit_out;

  always_comb begin
    chain_a[0]            = mul_pay;
    chain_a[0].slot.valid = mul_v;
  end

  genvar gi;
  generate
    for (gi = 0; gi < NUM_W; gi++) begin : g_range
      pdrs_div_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .din  (chain_a[gi]),
        .dout (chain_a[gi+1])
      );
    end
  endgenerate

  pdrs_fit u_fit (
    .clk           (clk),
    .rst           (rst),
    .base_clock_hz (base_clock_hz),
    .din           (chain_a[NUM_W]),
    .dout          (fit_out)
  );

  // achieved frequency division chain
  assign chain_b[0] = fit_out;

  generate
    for (gi = 0; gi < NUM_W; gi++) begin : g_freq
      pdrs_div_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .din  (chain_b[gi]),
        .dout (chain_b[gi+1])
      );
    end
  endgenerate

  logic    res_valid;
  result_t res;

  pdrs_select u_select (
    .clk       (clk),
    .rst       (rst),
    .din       (chain_b[NUM_W]),
    .res_valid (res_valid),
    .res       (res)
  );

  // two-entry result queue
  result_t   q0;
  result_t   q1;
  logic [1:0] qcnt;
  logic [1:0] wpos;

  assign pop  = (qcnt != 2'd0) && m_axis_tready;
  assign wpos = qcnt - {1'b0, pop};

  always_ff @(posedge clk) begin
    // a new item into an emptied head wins over the shift
    if (res_valid && wpos == 2'd0) begin
      q0 <= res;
    end else if (pop) begin
      q0 <= q1;
    end
    if (res_valid && wpos != 2'd0) begin
      q1 <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qcnt    <= 2'd0;
      pending <= 2'd0;
    end else begin
      qcnt    <= qcnt + {1'b0, res_valid} - {1'b0, pop};
      pending <= pending + {1'b0, accept} - {1'b0, pop};
    end
  end

  assign m_axis_tvalid = (qcnt != 2'd0);
  assign m_axis_tdata  = {6'd0, q0.achieved_freq, q0.compare_value, q0.period_range,
                          q0.clock_divider, q0.pin_number, q0.status};
endmodule

[design/pdrs_checker.sv]
// port-level checks of the pwm divider range search, bound to the top level
// depends on pdrs_pkg and pwm_divider_range_search_assert.svh
`include "pwm_divider_range_search_assert.svh"
module pdrs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [pdrs_pkg::OUT_W-1:0]   m_axis_tdata
);
  import pdrs_pkg::*;

  `PDRS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `PDRS_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tdata[2:0] <= ST_NO_FIT)
  `PDRS_ASSERT_NOW(a_err_zero, m_axis_tvalid && m_axis_tdata[2:0] != ST_OK, m_axis_tdata[89:3] == '0)
  `PDRS_ASSERT_NOW(a_ok_fields, m_axis_tvalid && m_axis_tdata[2:0] == ST_OK, m_axis_tdata[16:8] != '0 && m_axis_tdata[33:17] != '0)
endmodule

bind pwm_divider_range_search pdrs_checker u_pdrs_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/testbench.sv]
// self-checking testbench for pwm_divider_range_search
// depends on pdrs_pkg and the pwm_divider_range_search rtl
module testbench;
  import pdrs_pkg::*;

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  // channel[2:0], target_freq[42:3], duty_frac[58:43], zero fill
  logic [IN_W-1:0]   s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  // status[2:0], pin_number[7:3], clock_divider[16:8], period_range[33:17],
  // compare_value[49:34], achieved_freq[89:50], zero fill
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_wen;
  logic [BASE_W-1:0] cfg_wdata;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = 150;

  // one directed request; want_fixed marks a row with the result typed in
  typedef struct {
    logic [CH_W-1:0]   channel;
    logic [FREQ_W-1:0] freq;
    logic [DUTY_W-1:0] duty;
    bit                want_fixed;
    result_t           fixed;
  } request_row_t;

  result_t           setting_q[$];   // results still to come, oldest first
  logic [BASE_W-1:0] base_hz;        // our copy of base_clock_hz
  int                mismatches;
  int                cycles;
  bit                quiet;          // no idling on either side while set

  pwm_divider_range_search dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // n / d rounded half up
  function automatic bit [63:0] round_div(bit [63:0] n, bit [63:0] d);
    return n / d + (((n % d) * 2 >= d) ? 64'd1 : 64'd0);
  endfunction

  // full divider scan for one request at the current base clock
  function automatic result_t predict_setting(logic [CH_W-1:0] ch,
                                              logic [FREQ_W-1:0] freq,
                                              logic [DUTY_W-1:0] duty);
    result_t   res;
    bit [63:0] num, den, quo, rem, rng, ach, err;
    bit [63:0] best_div, best_rng, best_ach, best_err, cmp;
    bit        found;
    res = '0;
    num = 64'(base_hz) << FREQ_FRAC_BITS;
    found = 1'b0;
    best_div = 0; best_rng = 0; best_ach = 0; best_err = 0;
    if (ch < 1 || ch > 4) begin
      res.status = ST_BAD_CHANNEL;
      return res;
    end
    if (freq == 0) begin
      res.status = ST_BAD_FREQ;
      return res;
    end
    if (duty == 0) begin
      res.status = ST_BAD_DUTY;
      return res;
    end
    for (int dv = 1; dv <= MAX_DIVIDER; dv++) begin
      den = 64'(dv) * 64'(freq);
      quo = num / den;
      rem = num % den;
      // quotient must land in 1..MAX_RANGE exactly
      if (quo == 0) continue;
      if (quo > MAX_RANGE || (quo == MAX_RANGE && rem != 0)) continue;
      rng = round_div(num, den);
      ach = round_div(num, 64'(dv) * rng);
      err = (ach >= 64'(freq)) ? ach - 64'(freq) : 64'(freq) - ach;
      // strict compare keeps the earliest divider on a tie
      if (!found || err < best_err) begin
        found = 1'b1;
        best_err = err; best_div = 64'(dv); best_rng = rng; best_ach = ach;
      end
    end
    if (!found) begin
      res.status = ST_NO_FIT;
      return res;
    end
    cmp = (64'(duty) * best_rng + 64'd32768) >> 16;
    if (cmp < 1) cmp = 1;
    if (cmp >= best_rng) cmp = best_rng - 1;   // range of one gives zero
    res.status        = ST_OK;
    res.pin_number    = (ch == 1) ? 5'd21 : (ch == 2) ? 5'd22 : (ch == 3) ? 5'd2 : 5'd9;
    res.clock_divider = best_div[DIV_W-1:0];
    res.period_range  = best_rng[RANGE_W-1:0];
    res.compare_value = cmp[CMP_W-1:0];
    res.achieved_freq = best_ach[FREQ_W-1:0];
    return res;
  endfunction

  // a typed-in error result: status only, everything else zero
  function automatic result_t err_result(logic [STAT_W-1:0] st);
    result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  // send one item; the expectation is queued at the accepting edge
  task automatic send_item(logic [CH_W-1:0] ch, logic [FREQ_W-1:0] freq,
                           logic [DUTY_W-1:0] duty, bit fixed, result_t want);
    while (!quiet && $urandom_range(99) < 7) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {5'd0, duty, freq, ch};
    do @(posedge clk); while (!s_axis_tready);
    setting_q.push_back(fixed ? want : predict_setting(ch, freq, duty));
    @(negedge clk);
  endtask

  // block goes idle: every result in, then the pipeline drains
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (setting_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_base(logic [BASE_W-1:0] value);
    cfg_wen   = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wen   = 1'b0;
    base_hz   = value;
  endtask

  // random request; mostly well-formed with a wide spread of frequencies
  task automatic send_random();
    logic [CH_W-1:0]   ch;
    logic [FREQ_W-1:0] freq;
    logic [DUTY_W-1:0] duty;
    int                width;
    int                pick;
    pick  = $urandom_range(99);
    ch    = CH_W'($urandom_range(1, 4));
    width = $urandom_range(1, FREQ_W);
    freq  = FREQ_W'({$urandom, $urandom} & ((64'd1 << width) - 64'd1));
    if (freq == 0) freq = 1;
    duty  = DUTY_W'($urandom);
    if (duty == 0) duty = 1;
    if (pick < 5) ch = CH_W'($urandom_range(7));   // any channel, bad ones included
    else if (pick < 8) freq = 0;
    else if (pick < 11) duty = 0;
    else if (pick < 14) duty = 16'hffff;
    send_item(ch, freq, duty, 1'b0, '0);
  endtask

  request_row_t directed[$];
  result_t      fixed_res;
  logic [BASE_W-1:0] phase_base[6];

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;
    base_hz   = BASE_RESET;
    quiet     = 1'b0;
    mismatches = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // error codes, in check order, and the extremes of each field
    directed.push_back('{3'd0, 40'd100000, 16'd1000, 1'b1, err_result(ST_BAD_CHANNEL)});
    directed.push_back('{3'd7, 40'd0, 16'd0, 1'b1, err_result(ST_BAD_CHANNEL)});
    directed.push_back('{3'd5, 40'd256000, 16'd1, 1'b1, err_result(ST_BAD_CHANNEL)});
    directed.push_back('{3'd6, 40'd256000, 16'd1, 1'b1, err_result(ST_BAD_CHANNEL)});
    directed.push_back('{3'd1, 40'd0, 16'd0, 1'b1, err_result(ST_BAD_FREQ)});
    directed.push_back('{3'd4, 40'd0, 16'hffff, 1'b1, err_result(ST_BAD_FREQ)});
    directed.push_back('{3'd2, 40'd256000, 16'd0, 1'b1, err_result(ST_BAD_DUTY)});
    // frequency far above the base clock: no divider fits
    directed.push_back('{3'd3, 40'hff_ffff_ffff, 16'h8000, 1'b1, err_result(ST_NO_FIT)});
    // target equal to base clock: divider 1, range of one, compare forced to zero
    fixed_res = '{ST_OK, 5'd21, 9'd1, 17'd1, 16'd0, 40'd6153830400};
    directed.push_back('{3'd1, 40'd6153830400, 16'h8000, 1'b1, fixed_res});
    // every channel and both duty extremes, checked by the predictor
    directed.push_back('{3'd1, 40'd256000, 16'd1, 1'b0, '0});
    directed.push_back('{3'd2, 40'd256000, 16'hffff, 1'b0, '0});
    directed.push_back('{3'd3, 40'd25600, 16'h8000, 1'b0, '0});
    directed.push_back('{3'd4, 40'd12800, 16'h4000, 1'b0, '0});
    directed.push_back('{3'd1, 40'd1, 16'h0001, 1'b0, '0});
    directed.push_back('{3'd2, 40'd367, 16'hffff, 1'b0, '0});
    directed.push_back('{3'd3, 40'd3076915200, 16'h7fff, 1'b0, '0});
    directed.push_back('{3'd4, 40'd2000000000, 16'h0002, 1'b0, '0});
    directed.push_back('{3'd1, 40'h55_5555_5555, 16'h5555, 1'b0, '0});
    directed.push_back('{3'd2, 40'd100, 16'haaaa, 1'b0, '0});
    foreach (directed[i])
      send_item(directed[i].channel, directed[i].freq, directed[i].duty,
                directed[i].want_fixed, directed[i].fixed);

    // sender holds off until every result is back
    wait_idle();

    // base clock settings, extremes included, then back to the reset value
    phase_base[0] = BASE_RESET;
    phase_base[1] = 32'hffff_ffff;
    phase_base[2] = 32'd1;
    phase_base[3] = $urandom;
    phase_base[4] = 32'd10_000_000;
    phase_base[5] = BASE_RESET;
    for (int p = 0; p < 6; p++) begin
      if (p != 0) write_base(phase_base[p]);
      for (int n = 0; n < 300; n++) begin
        // a long stretch with no idling in the middle phase
        quiet = (p == 3 && n >= 50 && n < 250);
        send_random();
      end
      quiet = 1'b0;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("pwm_divider_range_search test passed");
    end else begin
      $display("pwm_divider_range_search test failed");
    end
    $finish;
  end

  // receiver stalls at random, except in the quiet stretch
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 7);
    end
  end

  // compare each accepted item with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (setting_q.size() == 0) begin
        $error("result item with nothing expected");
        mismatches++;
      end else begin
        want = setting_q.pop_front();
        if (m_axis_tdata[2:0] !== want.status) begin
          $error("status expected %0d actual %0d", want.status, m_axis_tdata[2:0]);
          mismatches++;
        end
        if (m_axis_tdata[7:3] !== want.pin_number) begin
          $error("pin_number expected %0d actual %0d", want.pin_number, m_axis_tdata[7:3]);
          mismatches++;
        end
        if (m_axis_tdata[16:8] !== want.clock_divider) begin
          $error("clock_divider expected %0d actual %0d",
                 want.clock_divider, m_axis_tdata[16:8]);
          mismatches++;
        end
        if (m_axis_tdata[33:17] !== want.period_range) begin
          $error("period_range expected %0d actual %0d",
                 want.period_range, m_axis_tdata[33:17]);
          mismatches++;
        end
        if (m_axis_tdata[49:34] !== want.compare_value) begin
          $error("compare_value expected %0d actual %0d",
                 want.compare_value, m_axis_tdata[49:34]);
          mismatches++;
        end
        if (m_axis_tdata[89:50] !== want.achieved_freq) begin
          $error("achieved_freq expected %0d actual %0d",
                 want.achieved_freq, m_axis_tdata[89:50]);
          mismatches++;
        end
      end
    end
  end

  // guard against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pwm_divider_range_search test failed");
      $finish;
    end
  end

  initial cycles = 0;

endmodule
